@@ rtl/core/serial_frame_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent assertion forms, synchronous to clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define SFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial_frame_receiver: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial_frame_receiver: next-cycle check failed");

`endif

@@ rtl/core/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Payload limits, parse phases, result kinds and register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Largest payload kept in the payload store
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);

  // Configuration register indexes
  localparam logic [1:0] CFG_START_BYTE   = 2'd0;
  localparam logic [1:0] CFG_END_BYTE     = 2'd1;
  localparam logic [1:0] CFG_CONNECT_CODE = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_BYTE_RST   = 8'd35;
  localparam logic [7:0] END_BYTE_RST     = 8'd36;
  localparam logic [7:0] CONNECT_CODE_RST = 8'd1;

  // Sequence id meaning "none yet"
  localparam logic [7:0] ID_NONE = 8'd255;

  // Parser phases
  typedef enum logic [2:0] {
    PH_START,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_END
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_BAD_END,
    KIND_BAD_CHECK,
    KIND_RESEND,
    KIND_OVERFLOW
  } kind_t;

endpackage

@@ rtl/core/sfr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold last word when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/serial_frame_receiver.sv @@
// Timing: a frame is judged when its end byte is accepted; an error or resend word
//   appears in the next cycle, the first payload word after RAM read and output registers.
// Throughput: one byte per cycle while a frame is received and input is not stalled;
//   payload words leave through the single RAM read port, with input stalled meanwhile.
//   An end byte also waits while a result word is still held at the output.
// Reset: synchronous, active low; clears parser, readout and output valid, reloads
//   configuration reset values; payload RAM keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Serial frame receiver
// Deframes start/id/length/payload/checksum/end packets and emits the payload.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_defines.svh"

module serial_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_seq_id,
  output logic [7:0] out_frame_length,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic       out_id_mismatch,
  output logic       out_last,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = sfr_pkg::ADDR_W;

  // configuration
  logic [7:0] start_byte_r, end_byte_r, connect_code_r;

  // parser state
  sfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] frame_id_r, frame_id_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] check_r, check_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] prev_id_r, prev_id_nxt;
  logic [7:0] reply_id_r, reply_id_nxt;

  // readout state
  logic          rd_act_r, rd_act_nxt;
  logic          q_ok_r, q_ok_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_mis_r, rd_mis_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  sfr_pkg::kind_t  out_kind_r, out_kind_nxt;
  logic [7:0]      out_pid_r, out_pid_nxt;
  logic [7:0]      out_len_r, out_len_nxt;
  logic [4:0]      out_idx_r, out_idx_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic            out_mis_r, out_mis_nxt;
  logic            out_last_r, out_last_nxt;

  // judgement results
  logic            jd_single;
  sfr_pkg::kind_t  jd_kind;
  logic            jd_mis;
  logic            jd_start_rd;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_q;

  logic       in_acc;
  logic       out_free;
  logic       rd_last;
  logic [7:0] prev_eff;
  logic [7:0] expected;

  assign in_stall  = rd_act_r || (phase_r == sfr_pkg::PH_END && out_valid_r);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= sfr_pkg::START_BYTE_RST;
      end_byte_r     <= sfr_pkg::END_BYTE_RST;
      connect_code_r <= sfr_pkg::CONNECT_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::CFG_START_BYTE:   start_byte_r   <= cfg_data;
        sfr_pkg::CFG_END_BYTE:     end_byte_r     <= cfg_data;
        sfr_pkg::CFG_CONNECT_CODE: connect_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence id check: a connect code restarts numbering
  always_comb begin
    prev_eff = (length_r != 8'd0 && first_r == connect_code_r) ? sfr_pkg::ID_NONE
                                                                 : prev_id_r;
    expected = (prev_eff == sfr_pkg::ID_NONE) ? 8'd0 : prev_eff + 8'd1;
  end

  // Parser: next phase, frame fields and end-of-frame judgement
  always_comb begin
    phase_nxt    = phase_r;
    frame_id_nxt = frame_id_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    check_nxt    = check_r;
    ovf_nxt      = ovf_r;
    first_nxt    = first_r;
    prev_id_nxt  = prev_id_r;
    reply_id_nxt = reply_id_r;
    jd_single    = 1'b0;
    jd_kind      = sfr_pkg::KIND_DATA;
    jd_mis       = 1'b0;
    jd_start_rd  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    if (in_acc) begin
      unique case (phase_r)
        sfr_pkg::PH_START: begin
          if (in_rx_byte == start_byte_r) begin
            phase_nxt = sfr_pkg::PH_ID;
          end
        end
        sfr_pkg::PH_ID: begin
          frame_id_nxt = in_rx_byte;
          xor_nxt      = in_rx_byte;
          phase_nxt    = sfr_pkg::PH_LEN;
        end
        sfr_pkg::PH_LEN: begin
          length_nxt = in_rx_byte;
          xor_nxt    = xor_r ^ in_rx_byte;
          count_nxt  = 8'd0;
          ovf_nxt    = in_rx_byte > 8'(sfr_pkg::MAX_PAYLOAD);
          phase_nxt  = (in_rx_byte == 8'd0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_DATA;
        end
        sfr_pkg::PH_DATA: begin
          // store while room remains, count and checksum every byte
          ram_we    = count_r < 8'(sfr_pkg::MAX_PAYLOAD);
          if (count_r == 8'd0) begin
            first_nxt = in_rx_byte;
          end
          xor_nxt   = xor_r ^ in_rx_byte;
          count_nxt = count_r + 8'd1;
          if (count_r + 8'd1 == length_r) begin
            phase_nxt = sfr_pkg::PH_CHECK;
          end
        end
        sfr_pkg::PH_CHECK: begin
          check_nxt = in_rx_byte;
          phase_nxt = sfr_pkg::PH_END;
        end
        sfr_pkg::PH_END: begin
          phase_nxt = sfr_pkg::PH_START;
          if (in_rx_byte != end_byte_r) begin
            jd_single    = 1'b1;
            jd_kind      = sfr_pkg::KIND_BAD_END;
            reply_id_nxt = frame_id_r;
          end else if (ovf_r) begin
            jd_single    = 1'b1;
            jd_kind      = sfr_pkg::KIND_OVERFLOW;
            reply_id_nxt = frame_id_r;
          end else if (xor_r != check_r) begin
            jd_single    = 1'b1;
            jd_kind      = sfr_pkg::KIND_BAD_CHECK;
            reply_id_nxt = frame_id_r;
          end else if (frame_id_r != expected && frame_id_r == reply_id_r) begin
            // resend request; the sequence restart still sticks
            jd_single   = 1'b1;
            jd_kind     = sfr_pkg::KIND_RESEND;
            prev_id_nxt = prev_eff;
          end else begin
            jd_mis       = frame_id_r != expected;
            prev_id_nxt  = frame_id_r;
            reply_id_nxt = frame_id_r;
            if (length_r == 8'd0) begin
              jd_single = 1'b1;
            end else begin
              jd_start_rd = 1'b1;
            end
          end
        end
        default: phase_nxt = sfr_pkg::PH_START;
      endcase
    end
  end

  // Readout sequencer and output register loading
  assign rd_last = (8'(rd_idx_r) + 8'd1) == length_r;

  always_comb begin
    rd_act_nxt    = rd_act_r;
    q_ok_nxt      = q_ok_r;
    rd_idx_nxt    = rd_idx_r;
    rd_mis_nxt    = rd_mis_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_pid_nxt   = out_pid_r;
    out_len_nxt   = out_len_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    out_mis_nxt   = out_mis_r;
    out_last_nxt  = out_last_r;
    if (jd_single) begin
      // single result word
      out_valid_nxt = 1'b1;
      out_kind_nxt  = jd_kind;
      out_pid_nxt   = frame_id_r;
      out_len_nxt   = length_r;
      out_idx_nxt   = 5'd0;
      out_data_nxt  = 8'd0;
      out_mis_nxt   = jd_mis;
      out_last_nxt  = 1'b1;
    end else if (jd_start_rd) begin
      // open readout and fetch the first word
      rd_act_nxt = 1'b1;
      rd_mis_nxt = jd_mis;
      rd_idx_nxt = '0;
      ram_re     = 1'b1;
      ram_raddr  = '0;
      q_ok_nxt   = 1'b1;
    end else if (rd_act_r) begin
      if (!q_ok_r) begin
        ram_re   = 1'b1;
        q_ok_nxt = 1'b1;
      end else if (out_free) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = sfr_pkg::KIND_DATA;
        out_pid_nxt   = frame_id_r;
        out_len_nxt   = length_r;
        out_idx_nxt   = 5'(rd_idx_r);
        out_data_nxt  = ram_q;
        out_mis_nxt   = rd_mis_r;
        out_last_nxt  = rd_last;
        if (rd_last) begin
          rd_act_nxt = 1'b0;
          q_ok_nxt   = 1'b0;
        end else begin
          // advance and fetch the next word in the same cycle
          rd_idx_nxt = rd_idx_r + AW'(1);
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r + AW'(1);
        end
      end
    end
  end

  // Control and frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sfr_pkg::PH_START;
      frame_id_r  <= 8'd0;
      length_r    <= 8'd0;
      count_r     <= 8'd0;
      xor_r       <= 8'd0;
      check_r     <= 8'd0;
      ovf_r       <= 1'b0;
      first_r     <= 8'd0;
      prev_id_r   <= sfr_pkg::ID_NONE;
      reply_id_r  <= sfr_pkg::ID_NONE;
      rd_act_r    <= 1'b0;
      q_ok_r      <= 1'b0;
      rd_idx_r    <= '0;
      rd_mis_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      frame_id_r  <= frame_id_nxt;
      length_r    <= length_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      check_r     <= check_nxt;
      ovf_r       <= ovf_nxt;
      first_r     <= first_nxt;
      prev_id_r   <= prev_id_nxt;
      reply_id_r  <= reply_id_nxt;
      rd_act_r    <= rd_act_nxt;
      q_ok_r      <= q_ok_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_mis_r    <= rd_mis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_pid_r  <= out_pid_nxt;
    out_len_r  <= out_len_nxt;
    out_idx_r  <= out_idx_nxt;
    out_data_r <= out_data_nxt;
    out_mis_r  <= out_mis_nxt;
    out_last_r <= out_last_nxt;
  end

  // Payload store
  sfr_ram #(
    .WIDTH(8),
    .DEPTH(sfr_pkg::MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_rx_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_seq_id       = out_pid_r;
  assign out_frame_length = out_len_r;
  assign out_byte_index   = out_idx_r;
  assign out_data_byte    = out_data_r;
  assign out_id_mismatch  = out_mis_r;
  assign out_last         = out_last_r;

  // Checks
  `SFR_ASSERT_IMPLY(a_rd_blocks_input, clk, rst_n, rd_act_r, in_stall)
  `SFR_ASSERT_IMPLY(a_rd_in_range, clk, rst_n, rd_act_r, 8'(rd_idx_r) < length_r)
  `SFR_ASSERT_IMPLY(a_err_is_last, clk, rst_n,
                    out_valid_r && out_kind_r != sfr_pkg::KIND_DATA, out_last_r)
  `SFR_ASSERT_NEXT(a_end_returns, clk, rst_n, in_acc && phase_r == sfr_pkg::PH_END,
                   phase_r == sfr_pkg::PH_START)

endmodule

@@ sim/serial_frame_receiver_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame receiver checker
// Watches the byte, result and register channels, deframes the accepted bytes
// on its own, and compares every result word with the oldest expected one.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checker
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_seq_id,
  input  logic [7:0] out_frame_length,
  input  logic [4:0] out_byte_index,
  input  logic [7:0] out_data_byte,
  input  logic       out_id_mismatch,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pending
);

  typedef struct {
    kind_t      kind;
    logic [7:0] seq_id;
    logic [7:0] frame_length;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic       id_mismatch;
    logic       last;
  } frame_result_t;

  frame_result_t frame_results[$];

  // Register copies
  logic [7:0] start_code, end_code, connect_val;

  // Deframer state
  phase_t     phase;
  logic [7:0] cur_id, cur_len, rx_count, xor_sum, sent_check;
  logic       too_long;
  logic [7:0] payload [MAX_PAYLOAD];
  logic [7:0] prev_id, reply_id;

  initial mismatches = 0;
  assign pending = frame_results.size();

  function void queue_result(kind_t k, logic [4:0] idx, logic [7:0] data, logic mis,
                             logic fin);
    frame_result_t r;
    r.kind         = k;
    r.seq_id       = cur_id;
    r.frame_length = cur_len;
    r.byte_index   = idx;
    r.data_byte    = data;
    r.id_mismatch  = mis;
    r.last         = fin;
    frame_results.push_back(r);
  endfunction

  // Judge a frame on its closing byte: end code, overflow, checksum, then sequence
  function void judge_frame(logic [7:0] c);
    logic [7:0] want_id;
    logic       mis;
    int         i;
    if (c != end_code) begin
      reply_id = cur_id;
      queue_result(KIND_BAD_END, 5'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    if (too_long) begin
      reply_id = cur_id;
      queue_result(KIND_OVERFLOW, 5'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    if (xor_sum != sent_check) begin
      reply_id = cur_id;
      queue_result(KIND_BAD_CHECK, 5'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    // A connect code in the first payload byte restarts numbering
    if (cur_len != 8'd0 && payload[0] == connect_val)
      prev_id = ID_NONE;
    want_id = (prev_id == ID_NONE) ? 8'd0 : prev_id + 8'd1;
    mis = (cur_id != want_id);
    if (mis && cur_id == reply_id) begin
      queue_result(KIND_RESEND, 5'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    prev_id  = cur_id;
    reply_id = cur_id;
    if (cur_len == 8'd0)
      queue_result(KIND_DATA, 5'd0, 8'd0, mis, 1'b1);
    else
      for (i = 0; i < cur_len && i < MAX_PAYLOAD; i++)
        queue_result(KIND_DATA, i[4:0], payload[i], mis, (i + 1 == cur_len));
  endfunction

  // Advance the deframer by one received byte
  function void deframe_byte(logic [7:0] c);
    case (phase)
      PH_ID: begin
        cur_id  = c;
        xor_sum = c;
        phase   = PH_LEN;
      end
      PH_LEN: begin
        cur_len  = c;
        xor_sum  = xor_sum ^ c;
        rx_count = 8'd0;
        too_long = (c > MAX_PAYLOAD);
        phase    = (c == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        if (rx_count < MAX_PAYLOAD)
          payload[rx_count[ADDR_W-1:0]] = c;
        xor_sum  = xor_sum ^ c;
        rx_count = rx_count + 8'd1;
        if (rx_count == cur_len)
          phase = PH_CHECK;
      end
      PH_CHECK: begin
        sent_check = c;
        phase      = PH_END;
      end
      PH_END: begin
        phase = PH_START;
        judge_frame(c);
      end
      default: begin
        phase = (c == start_code) ? PH_ID : PH_START;
      end
    endcase
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare outgoing words first, then take register writes and new bytes
  always @(posedge clk) begin
    frame_result_t r;
    if (!rst_n) begin
      start_code  = START_BYTE_RST;
      end_code    = END_BYTE_RST;
      connect_val = CONNECT_CODE_RST;
      phase       = PH_START;
      cur_id      = 8'd0;
      cur_len     = 8'd0;
      rx_count    = 8'd0;
      xor_sum     = 8'd0;
      sent_check  = 8'd0;
      too_long    = 1'b0;
      prev_id     = ID_NONE;
      reply_id    = ID_NONE;
      frame_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d id %0d", out_kind,
                 out_seq_id);
          mismatches++;
        end else begin
          r = frame_results.pop_front();
          check_field("kind", r.kind, out_kind);
          check_field("seq_id", r.seq_id, out_seq_id);
          check_field("frame_length", r.frame_length, out_frame_length);
          check_field("byte_index", r.byte_index, out_byte_index);
          check_field("data_byte", r.data_byte, out_data_byte);
          check_field("id_mismatch", r.id_mismatch, out_id_mismatch);
          check_field("last", r.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_BYTE:   start_code  = cfg_data;
          CFG_END_BYTE:     end_code    = cfg_data;
          CFG_CONNECT_CODE: connect_val = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        deframe_byte(in_rx_byte);
    end
  end

endmodule

@@ sim/serial_frame_receiver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Sends directed and random frames, with noise, under several register settings
// and handshake pressure; the checker beside the block judges every word.
// ----------------------------------------------------------------------------
module serial_frame_receiver_tb;
  import sfr_pkg::*;

  // Frame flaws
  localparam int FLAW_NONE  = 0;
  localparam int FLAW_END   = 1;
  localparam int FLAW_CHECK = 2;

  localparam int RANDOM_BYTES = 220;
  localparam int SETTLE       = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_seq_id;
  logic [7:0] out_frame_length;
  logic [4:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic       out_id_mismatch;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_START_BYTE;
  logic [7:0] cfg_data = 8'd0;

  int mismatches, pending;

  // Stimulus-side copies of the registers and the sequence
  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_end = END_BYTE_RST;
  logic [7:0] cur_connect = CONNECT_CODE_RST;
  logic [7:0] next_id = 8'd0;
  int         in_idle_pct = 0;
  int         out_stall_pct = 0;
  int         random_bytes = 0;

  serial_frame_receiver dut (.*);

  serial_frame_receiver_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at the current rate
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < out_stall_pct);

  // Offer one byte, with random idle cycles ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input logic [7:0] id, input int len, input bit connect,
                            input int flaw);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = id ^ len[7:0];
    send_byte(cur_start);
    send_byte(id);
    send_byte(len[7:0]);
    for (i = 0; i < len; i++) begin
      b = (i == 0 && connect) ? cur_connect : 8'($urandom_range(255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (flaw == FLAW_CHECK)
      sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    b = cur_end;
    if (flaw == FLAW_END)
      b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
    random_bytes += len + 5;
  endtask

  // Drop valid and wait until every expected word is out and the block settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] s, input logic [7:0] e,
                           input logic [7:0] c);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_END_BYTE;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CONNECT_CODE;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_start   = s;
    cur_end     = e;
    cur_connect = c;
  endtask

  // One random frame, sometimes preceded by line noise or a garbled burst
  task automatic random_frame();
    logic [7:0] id, b;
    int         len, flaw, r, n;
    bit         connect;
    r = $urandom_range(99);
    if (r < 15) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        do b = 8'($urandom_range(255)); while (b == cur_start);
        send_byte(b);
      end
    end else if (r < 19) begin
      n = $urandom_range(3, 8);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
    r = $urandom_range(99);
    if (r < 8)       len = 0;
    else if (r < 80) len = $urandom_range(1, 8);
    else if (r < 88) len = $urandom_range(9, 31);
    else if (r < 94) len = MAX_PAYLOAD;
    else             len = $urandom_range(MAX_PAYLOAD + 1, 40);
    r = $urandom_range(99);
    flaw = (r < 8) ? FLAW_END : (r < 16) ? FLAW_CHECK : FLAW_NONE;
    connect = 1'b0;
    r = $urandom_range(99);
    if (r < 10) begin
      connect = 1'b1;
      id = ($urandom_range(3) != 0) ? 8'd0 : 8'($urandom_range(255));
    end else if (r < 18) begin
      id = next_id - 8'd1;
    end else if (r < 26) begin
      id = 8'($urandom_range(255));
    end else begin
      id = next_id;
    end
    send_frame(id, len, connect, flaw);
    if (flaw == FLAW_NONE)
      next_id = id + 8'd1;
  endtask

  initial begin : stimulus
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes as noise, then each frame case at reset settings
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd0, 0, 1'b0, FLAW_NONE);   // empty frame, first in sequence
    send_frame(8'd0, 2, 1'b1, FLAW_NONE);   // connect restarts numbering
    send_frame(8'd0, 1, 1'b0, FLAW_NONE);   // repeat of last reply id
    send_frame(8'd1, 0, 1'b0, FLAW_END);    // wrong closing byte
    send_frame(8'd1, 1, 1'b0, FLAW_CHECK);  // wrong checksum
    send_frame(8'd9, 3, 1'b0, FLAW_NONE);   // out-of-sequence id, still delivered
    send_frame(8'd10, MAX_PAYLOAD + 1, 1'b1, FLAW_NONE);  // too long
    send_frame(8'd0, 0, 1'b0, FLAW_NONE);   // empty frame must not restart
    send_frame(8'd11, MAX_PAYLOAD, 1'b0, FLAW_NONE);      // longest stored
    random_bytes = 0;
    next_id = 8'd12;

    // Random: four pressure modes, each under its own register setting
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          configure(8'h00, 8'hFF, 8'h00);
          in_idle_pct = 0;
          out_stall_pct <= 0;
        end
        1: begin
          configure(8'hFF, 8'h00, 8'hFF);
          in_idle_pct = 46;
          out_stall_pct <= 0;
        end
        2: begin
          configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
          in_idle_pct = 0;
          out_stall_pct <= 46;
        end
        default: begin
          configure(START_BYTE_RST, END_BYTE_RST, CONNECT_CODE_RST);
          in_idle_pct = 31;
          out_stall_pct <= 31;
        end
      endcase
      while (random_bytes < RANDOM_BYTES * (ph + 1) / 4)
        random_frame();
    end

    // Drain and give the verdict
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("serial_frame_receiver_tb: PASS");
    else
      $display("serial_frame_receiver_tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("serial_frame_receiver_tb: FAIL");
    $finish;
  end

endmodule
